[sv/sdq_pkg.sv]
// Shared types and codes for the sorting deque with sign split.
// No dependencies; imported by sorting_deque_with_sign_split.
package sdq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 6;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SHOW_FWD   = 3'd4,
    OP_SHOW_BWD   = 3'd5,
    OP_SPLIT      = 3'd6
  } op_t;

  localparam logic [1:0] GRP_PLAIN = 2'd0;
  localparam logic [1:0] GRP_NEG   = 2'd1;
  localparam logic [1:0] GRP_POS   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ALLZERO = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHOW,
    S_SORT_LD,
    S_SORT_CMP,
    S_SORT_WB,
    S_SPL_CHK,
    S_SPL_END
  } state_t;

endpackage

[sv/sorting_deque_with_sign_split.sv]
// Bounded signed deque in a ring store, with in-place exchange sort and sign split.
// Depends on sdq_pkg (op codes, group and status codes, sequencer states).
//
// Usage: one input channel (in_op, in_value) and one result channel, both
// valid/stall. A transfer on the input is taken only while the sequencer is
// idle; in_stall is high for the whole of a show or split.
// Push and pop: one acknowledgement, registered, in the cycle after the transfer.
// Show: one result per entry, one per cycle while the receiver keeps up.
// Split: a single shared signed comparator walks the exchange sort, one pair
// of entries per cycle from a one-write one-read ring memory; each outer pass
// loads the entry at position i, compares it with every later entry, swapping
// on greater, and writes it back. A scan then sends out the nonzero values
// and a final result; the sort itself never waits for the receiver.
// A one-entry holding register delays each nonzero value so that the final
// one can carry last.
// Reset (rst_n low, synchronous) empties the queue and the output register;
// the store itself is not cleared, only entries that hold values are read.
// When the receiver stalls, the result register holds and show or scan waits,
// memory read data held, until the register is free; zero entries still pass.
module sorting_deque_with_sign_split
  import sdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_op,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_value_res,
  output logic [1:0]                out_group,
  output logic [1:0]                out_status,
  output logic [COUNT_W-1:0]        out_count,
  output logic                      out_last
);

  localparam int IW = $clog2(DEPTH);      // ring position
  localparam int CW = $clog2(DEPTH + 1);  // entry count and logical index

  // ---- state ----
  state_t                    state_r, state_nxt;
  logic [IW-1:0]             head_r, head_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic [CW-1:0]             j_r, j_nxt;
  logic signed [VALUE_W-1:0] cur_r, cur_nxt;    // element held for position i
  logic                      fwd_r, fwd_nxt;
  logic                      pend_v_r, pend_v_nxt;
  logic signed [VALUE_W-1:0] pend_r, pend_nxt;  // nonzero value awaiting last flag

  // ---- ring memory ----
  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic                      we;
  logic [IW-1:0]             wa;
  logic signed [VALUE_W-1:0] wd;
  logic                      re;
  logic [CW-1:0]             ra_idx;
  logic signed [VALUE_W-1:0] rd_q;

  // ---- result register ----
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [1:0]                out_group_r, out_status_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_last_r;

  logic                      ld, ld_last;
  logic signed [VALUE_W-1:0] ld_value;
  logic [1:0]                ld_group, ld_status;

  logic                      accept, out_free;
  op_t                       op;
  logic [IW-1:0]             head_dec, head_inc;
  logic [CW-1:0]             i_inc, j_inc;
  logic                      full, empty, swap, go;

  // logical index to ring position; idx is below DEPTH wherever the result is used
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(idx);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign op       = op_t'(in_op);

  assign head_dec = (head_r == '0) ? IW'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign i_inc    = i_r + 1'b1;
  assign j_inc    = j_r + 1'b1;
  assign full     = (cnt_r >= CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign swap     = (cur_r > rd_q);  // the one shared signed comparator
  assign go       = (rd_q == '0) || !pend_v_r || out_free;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !empty) begin
          case (op)
            OP_SHOW_FWD, OP_SHOW_BWD: state_nxt = S_SHOW;
            OP_SPLIT:                 state_nxt = S_SORT_LD;
            default:                  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SHOW: begin
        if (out_free && (i_inc == cnt_r)) state_nxt = S_IDLE;
      end
      S_SORT_LD: begin
        state_nxt = (i_inc < cnt_r) ? S_SORT_CMP : S_SPL_CHK;
      end
      S_SORT_CMP: begin
        if (j_inc >= cnt_r) state_nxt = S_SORT_WB;
      end
      S_SORT_WB: state_nxt = S_SORT_LD;
      S_SPL_CHK: begin
        if (go && (i_inc >= cnt_r)) state_nxt = S_SPL_END;
      end
      S_SPL_END: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- datapath control ----
  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cur_nxt    = cur_r;
    fwd_nxt    = fwd_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    we         = 1'b0;
    wa         = slot(head_r, j_r);
    wd         = cur_r;
    re         = 1'b0;
    ra_idx     = '0;
    ld         = 1'b0;
    ld_value   = '0;
    ld_group   = GRP_PLAIN;
    ld_status  = ST_OK;
    ld_last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                we      = 1'b1;
                wd      = in_value;
                cnt_nxt = cnt_r + 1'b1;
                if (op == OP_PUSH_FRONT) begin
                  wa       = head_dec;
                  head_nxt = head_dec;
                end else begin
                  wa = slot(head_r, cnt_r);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              ld = 1'b1;
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
                if (op == OP_POP_FRONT) head_nxt = head_inc;
              end
            end
            OP_SHOW_FWD, OP_SHOW_BWD: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                fwd_nxt = (op == OP_SHOW_FWD);
                i_nxt   = '0;
                re      = 1'b1;
                ra_idx  = (op == OP_SHOW_FWD) ? '0 : cnt_r - 1'b1;
              end
            end
            OP_SPLIT: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                i_nxt      = '0;
                re         = 1'b1;
                ra_idx     = '0;
                pend_v_nxt = 1'b0;
              end
            end
            default: ld = 1'b1;  // unused code: plain acknowledgement
          endcase
        end
      end
      S_SHOW: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_value = rd_q;
          ld_last  = (i_inc == cnt_r);
          if (i_inc != cnt_r) begin
            i_nxt  = i_inc;
            re     = 1'b1;
            ra_idx = fwd_r ? i_inc : cnt_r - 1'b1 - i_inc;
          end
        end
      end
      S_SORT_LD: begin
        cur_nxt = rd_q;
        j_nxt   = i_inc;
        re      = 1'b1;
        if (i_inc < cnt_r) begin
          ra_idx = i_inc;
        end else begin
          ra_idx = '0;  // sort done, start the scan
          i_nxt  = '0;
        end
      end
      S_SORT_CMP: begin
        if (swap) begin
          we      = 1'b1;
          wa      = slot(head_r, j_r);
          wd      = cur_r;
          cur_nxt = rd_q;
        end
        if (j_inc < cnt_r) begin
          j_nxt  = j_inc;
          re     = 1'b1;
          ra_idx = j_inc;
        end
      end
      S_SORT_WB: begin
        we     = 1'b1;
        wa     = slot(head_r, i_r);
        wd     = cur_r;
        i_nxt  = i_inc;
        re     = 1'b1;
        ra_idx = i_inc;
      end
      S_SPL_CHK: begin
        if (go) begin
          if (rd_q != '0) begin
            if (pend_v_r) begin
              ld       = 1'b1;
              ld_value = pend_r;
              ld_group = pend_r[VALUE_W-1] ? GRP_NEG : GRP_POS;
              ld_last  = 1'b0;
            end
            pend_nxt   = rd_q;
            pend_v_nxt = 1'b1;
          end
          if (i_inc < cnt_r) begin
            i_nxt  = i_inc;
            re     = 1'b1;
            ra_idx = i_inc;
          end
        end
      end
      S_SPL_END: begin
        if (out_free) begin
          ld = 1'b1;
          if (pend_v_r) begin
            ld_value = pend_r;
            ld_group = pend_r[VALUE_W-1] ? GRP_NEG : GRP_POS;
          end else begin
            ld_status = ST_ALLZERO;
          end
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---- ring memory: one write, one registered read ----
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[slot(head_r, ra_idx)];
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= ld || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    cur_r  <= cur_nxt;
    fwd_r  <= fwd_nxt;
    pend_r <= pend_nxt;
    if (ld) begin
      out_value_r  <= ld_value;
      out_group_r  <= ld_group;
      out_status_r <= ld_status;
      out_count_r  <= COUNT_W'(cnt_nxt);
      out_last_r   <= ld_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_group     = out_group_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;
  assign out_last      = out_last_r;

endmodule
